[hw/rtl/epi_pkg.sv]
// Shared constants, payload types and register codes of the epipolar inlier test.
package epi_pkg;

    // Field and coefficient widths
    localparam int COEF_W    = 20;
    localparam int COORD_W   = 20;
    localparam int FRAC_BITS = 4;                 // Q15.4 coordinates, 1.0 is 1 << FRAC_BITS
    localparam int ROW_W     = 60;
    localparam int ROW_PAD_W = (3 * COEF_W > ROW_W) ? 3 * COEF_W : ROW_W;
    localparam int THR_W     = 24;
    localparam int DIST_W    = 24;

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(512);

    // Datapath widths
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int L_W      = COEF_W + COORD_W + 2;    // epipolar line coefficient
    localparam int HALF_W   = (L_W + 1) / 2;           // low half of a split line value
    localparam int HIGH_W   = L_W - HALF_W;            // high half
    localparam int A_W      = 2 * L_W - 1;             // squared normal length
    localparam int RH_W     = COORD_W + HIGH_W;
    localparam int RL_W     = COORD_W + HALF_W + 1;
    localparam int R_W      = COORD_W + L_W + 1;       // residual p1.l2
    localparam int S_W      = R_W - 1 + FRAC_BITS;     // 16*|R|
    localparam int LIMB_W   = (S_W + 2) / 3;
    localparam int PP_W     = 2 * LIMB_W;
    localparam int RSQ_W    = 2 * S_W;
    localparam int Q_W      = 2 * DIST_W;              // quotient bits ahead of the root
    localparam int P0_W     = RSQ_W - Q_W;
    localparam int CMP_W    = (P0_W > A_W) ? P0_W : A_W;
    localparam int SQ_REM_W = DIST_W + 1;
    localparam int SQ_TRY_W = DIST_W + 3;
    localparam int LANE_LAT = 1 + Q_W + DIST_W;

    // Configuration port
    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 2;
    localparam int ADDR_LSB  = 3;
    localparam int ADDR_W    = REG_IDX_W + ADDR_LSB;

    localparam logic [REG_IDX_W-1:0] REG_F_ROW0     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_F_ROW1     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_F_ROW2     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } in_t;

    typedef struct packed {
        logic              is_inlier;
        logic [DIST_W-1:0] distance;
    } out_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0] f_row;
        logic [THR_W-1:0]      thr;
    } cfg_t;

    typedef struct packed {
        logic signed [L_W-1:0]     l1x;
        logic signed [L_W-1:0]     l1y;
        logic signed [L_W-1:0]     l2x;
        logic signed [L_W-1:0]     l2y;
        logic signed [L_W-1:0]     l2z;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } lines_t;

    typedef struct packed {
        logic [A_W-1:0]   a1;
        logic [A_W-1:0]   a2;
        logic [RSQ_W-1:0] rsq;
    } norm_t;

endpackage

[hw/rtl/epipolar_inlier_test.sv]
// Top level of the symmetric epipolar distance inlier test.
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    epi_pkg::in_t  (first_x, first_y, second_x, second_y)
//  m_        out  m_valid/m_ready    epi_pkg::out_t (is_inlier, distance)
//  apb       in   psel/penable/pwrite/pready, paddr 8*index, 64-bit data
//
// One correspondence per cycle unless frozen; input passes the line and norm stages, the
// divide and square-root stages (one bit each) and the output register to the output.
// Synchronous active-low reset clears valid bits and registers; data stages are not reset.
// A stalled result holds in the output register; the pipeline keeps moving while its last
// stage is empty or the output register is free or taken, and freezes as a whole otherwise.
module epipolar_inlier_test (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  epi_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output epi_pkg::out_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epi_pkg::ADDR_W-1:0]  paddr,
    input  logic [epi_pkg::DATA_W-1:0]  pwdata,
    output logic [epi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    epi_pkg::cfg_t                cfg;
    logic                         en;
    logic                         lines_v, norm_v;
    epi_pkg::lines_t              lines;
    epi_pkg::norm_t               norm;
    logic [epi_pkg::LANE_LAT-1:0] lane_v_reg;
    logic                         lane_last;
    logic [epi_pkg::DIST_W-1:0]   t1, t2;
    logic [epi_pkg::DIST_W:0]     sum;
    epi_pkg::out_t                out_next;
    logic                         m_valid_reg, m_valid_next;
    epi_pkg::out_t                m_data_reg;
    logic                         load;

    epi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline advance: output free, being taken, or the last stage holds a bubble
    assign lane_last = lane_v_reg[epi_pkg::LANE_LAT-1];
    assign en        = !m_valid_reg || m_ready || !lane_last;
    assign s_ready   = en;
    assign load      = en && lane_last;

    epi_lines u_lines (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_v     (s_valid),
        .in_data  (s_data),
        .f_row    (cfg.f_row),
        .out_v    (lines_v),
        .out_data (lines)
    );

    epi_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_v     (lines_v),
        .in_data  (lines),
        .out_v    (norm_v),
        .out_data (norm)
    );

    epi_lane u_lane1 (
        .aclk (aclk),
        .en   (en),
        .rsq  (norm.rsq),
        .a    (norm.a1),
        .term (t1)
    );

    epi_lane u_lane2 (
        .aclk (aclk),
        .en   (en),
        .rsq  (norm.rsq),
        .a    (norm.a2),
        .term (t2)
    );

    // valid bits alongside the divide/root lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_v_reg <= '0;
        end else if (en) begin
            lane_v_reg <= {lane_v_reg[epi_pkg::LANE_LAT-2:0], norm_v};
        end
    end

    // sum, saturate, compare
    always_comb begin
        sum                = {1'b0, t1} + {1'b0, t2};
        out_next.distance  = sum[epi_pkg::DIST_W] ? epi_pkg::DIST_MAX : sum[epi_pkg::DIST_W-1:0];
        out_next.is_inlier = out_next.distance < cfg.thr;
    end

    // output register
    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/epi_regs.sv]
// APB configuration registers: fundamental matrix rows and inlier threshold.
module epi_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epi_pkg::ADDR_W-1:0]  paddr,
    input  logic [epi_pkg::DATA_W-1:0]  pwdata,
    output logic [epi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output epi_pkg::cfg_t               cfg
);

    logic [2:0][epi_pkg::ROW_W-1:0]   f_row_reg;
    logic [epi_pkg::THR_W-1:0]        thr_reg;
    logic [epi_pkg::REG_IDX_W-1:0]    idx;
    logic                             wr;

    assign pready = 1'b1;
    assign idx    = paddr[epi_pkg::ADDR_W-1:epi_pkg::ADDR_LSB];
    assign wr     = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_row_reg <= '0;
            thr_reg   <= epi_pkg::THR_RESET;
        end else if (wr) begin
            case (idx)
                epi_pkg::REG_F_ROW0:    f_row_reg[0] <= pwdata[epi_pkg::ROW_W-1:0];
                epi_pkg::REG_F_ROW1:    f_row_reg[1] <= pwdata[epi_pkg::ROW_W-1:0];
                epi_pkg::REG_F_ROW2:    f_row_reg[2] <= pwdata[epi_pkg::ROW_W-1:0];
                epi_pkg::REG_THRESHOLD: thr_reg      <= pwdata[epi_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            epi_pkg::REG_F_ROW0:    prdata = epi_pkg::DATA_W'(f_row_reg[0]);
            epi_pkg::REG_F_ROW1:    prdata = epi_pkg::DATA_W'(f_row_reg[1]);
            epi_pkg::REG_F_ROW2:    prdata = epi_pkg::DATA_W'(f_row_reg[2]);
            epi_pkg::REG_THRESHOLD: prdata = epi_pkg::DATA_W'(thr_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.f_row = f_row_reg;
    assign cfg.thr   = thr_reg;

endmodule

[hw/rtl/epi_lines.sv]
// Front stages: epipolar lines F*p1 and F^T*p2 (products, then sums).
module epi_lines (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_v,
    input  epi_pkg::in_t                         in_data,
    input  logic [2:0][epi_pkg::ROW_W-1:0]       f_row,
    output logic                                 out_v,
    output epi_pkg::lines_t                      out_data
);

    logic [epi_pkg::ROW_PAD_W-1:0]      row_pad [3];
    logic signed [epi_pkg::COEF_W-1:0]  f [3][3];

    // stage 1 registers
    logic                               v1_reg;
    logic signed [epi_pkg::PROD_W-1:0]  p1x_reg [2];
    logic signed [epi_pkg::PROD_W-1:0]  p1y_reg [2];
    logic signed [epi_pkg::COEF_W-1:0]  c1_reg  [2];
    logic signed [epi_pkg::PROD_W-1:0]  p2x_reg [3];
    logic signed [epi_pkg::PROD_W-1:0]  p2y_reg [3];
    logic signed [epi_pkg::COEF_W-1:0]  c2_reg  [3];
    logic signed [epi_pkg::COORD_W-1:0] x1_reg, y1_reg;

    // stage 2 registers
    logic                               v2_reg;
    epi_pkg::lines_t                    lines_reg, lines_next;

    // unpack coefficients
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            row_pad[k] = epi_pkg::ROW_PAD_W'(f_row[k]);
            for (int c = 0; c < 3; c++) begin
                f[k][c] = $signed(row_pad[k][c*epi_pkg::COEF_W +: epi_pkg::COEF_W]);
            end
        end
    end

    // stage 1: coefficient times coordinate
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                p1x_reg[k] <= epi_pkg::PROD_W'(f[k][0]) * epi_pkg::PROD_W'(in_data.first_x);
                p1y_reg[k] <= epi_pkg::PROD_W'(f[k][1]) * epi_pkg::PROD_W'(in_data.first_y);
                c1_reg[k]  <= f[k][2];
            end
            for (int k = 0; k < 3; k++) begin
                p2x_reg[k] <= epi_pkg::PROD_W'(f[0][k]) * epi_pkg::PROD_W'(in_data.second_x);
                p2y_reg[k] <= epi_pkg::PROD_W'(f[1][k]) * epi_pkg::PROD_W'(in_data.second_y);
                c2_reg[k]  <= f[2][k];
            end
            x1_reg <= in_data.first_x;
            y1_reg <= in_data.first_y;
        end
    end

    // stage 2: line sums, homogeneous term is 1.0 in Q.4
    always_comb begin
        lines_next.l1x = epi_pkg::L_W'(p1x_reg[0]) + epi_pkg::L_W'(p1y_reg[0])
                       + (epi_pkg::L_W'(c1_reg[0]) <<< epi_pkg::FRAC_BITS);
        lines_next.l1y = epi_pkg::L_W'(p1x_reg[1]) + epi_pkg::L_W'(p1y_reg[1])
                       + (epi_pkg::L_W'(c1_reg[1]) <<< epi_pkg::FRAC_BITS);
        lines_next.l2x = epi_pkg::L_W'(p2x_reg[0]) + epi_pkg::L_W'(p2y_reg[0])
                       + (epi_pkg::L_W'(c2_reg[0]) <<< epi_pkg::FRAC_BITS);
        lines_next.l2y = epi_pkg::L_W'(p2x_reg[1]) + epi_pkg::L_W'(p2y_reg[1])
                       + (epi_pkg::L_W'(c2_reg[1]) <<< epi_pkg::FRAC_BITS);
        lines_next.l2z = epi_pkg::L_W'(p2x_reg[2]) + epi_pkg::L_W'(p2y_reg[2])
                       + (epi_pkg::L_W'(c2_reg[2]) <<< epi_pkg::FRAC_BITS);
        lines_next.x1  = x1_reg;
        lines_next.y1  = y1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lines_reg <= lines_next;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    assign out_v    = v2_reg;
    assign out_data = lines_reg;

endmodule

[hw/rtl/epi_norm.sv]
// Middle stages: squared normal lengths and squared scaled residual, split multiplies.
module epi_norm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_v,
    input  epi_pkg::lines_t  in_data,
    output logic             out_v,
    output epi_pkg::norm_t   out_data
);

    localparam int HH_W = 2 * epi_pkg::HIGH_W;
    localparam int HL_W = epi_pkg::HIGH_W + epi_pkg::HALF_W;
    localparam int LL_W = 2 * epi_pkg::HALF_W;
    localparam int SP_W = 3 * epi_pkg::LIMB_W;

    function automatic logic [epi_pkg::A_W-1:0] sq_sum(
        input logic [HH_W-1:0] hh,
        input logic [HL_W-1:0] hl,
        input logic [LL_W-1:0] ll
    );
        return (epi_pkg::A_W'(hh) << (2 * epi_pkg::HALF_W))
             + (epi_pkg::A_W'(hl) << (epi_pkg::HALF_W + 1))
             + epi_pkg::A_W'(ll);
    endfunction

    logic signed [epi_pkg::L_W-1:0]     lv [4];
    logic [epi_pkg::L_W-1:0]            lmag [4];
    logic signed [epi_pkg::COORD_W-1:0] rx [2];
    logic signed [epi_pkg::L_W-1:0]     rl [2];

    // stage 3 registers
    logic                               v3_reg;
    logic [HH_W-1:0]                    hh_reg [4];
    logic [HL_W-1:0]                    hl_reg [4];
    logic [LL_W-1:0]                    ll_reg [4];
    logic signed [epi_pkg::RH_W-1:0]    ph_reg [2];
    logic signed [epi_pkg::RL_W-1:0]    pl_reg [2];
    logic signed [epi_pkg::L_W-1:0]     l2z_reg;

    // stage 4 registers
    logic                               v4_reg;
    logic [epi_pkg::A_W-1:0]            a1_4_reg, a2_4_reg;
    logic signed [epi_pkg::R_W-1:0]     r_reg, r_next;

    // stage 5 registers
    logic                               v5_reg;
    logic [epi_pkg::A_W-1:0]            a1_5_reg, a2_5_reg;
    logic [epi_pkg::PP_W-1:0]           pp_reg [6];
    logic [epi_pkg::R_W-1:0]            rmag;
    logic [epi_pkg::S_W-1:0]            s_val;
    logic [SP_W-1:0]                    s_pad;
    logic [epi_pkg::LIMB_W-1:0]         limb [3];

    // stage 6 registers
    logic                               v6_reg;
    epi_pkg::norm_t                     norm_reg, norm_next;

    // stage 3: split squares of the normals and residual partial products
    always_comb begin
        lv[0] = in_data.l1x;
        lv[1] = in_data.l1y;
        lv[2] = in_data.l2x;
        lv[3] = in_data.l2y;
        for (int i = 0; i < 4; i++) begin
            lmag[i] = lv[i][epi_pkg::L_W-1] ? -lv[i] : lv[i];
        end
        rx[0] = in_data.x1;
        rx[1] = in_data.y1;
        rl[0] = in_data.l2x;
        rl[1] = in_data.l2y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                hh_reg[i] <= HH_W'(lmag[i][epi_pkg::L_W-1:epi_pkg::HALF_W])
                           * HH_W'(lmag[i][epi_pkg::L_W-1:epi_pkg::HALF_W]);
                hl_reg[i] <= HL_W'(lmag[i][epi_pkg::L_W-1:epi_pkg::HALF_W])
                           * HL_W'(lmag[i][epi_pkg::HALF_W-1:0]);
                ll_reg[i] <= LL_W'(lmag[i][epi_pkg::HALF_W-1:0])
                           * LL_W'(lmag[i][epi_pkg::HALF_W-1:0]);
            end
            for (int i = 0; i < 2; i++) begin
                ph_reg[i] <= epi_pkg::RH_W'(rx[i])
                           * epi_pkg::RH_W'($signed(rl[i][epi_pkg::L_W-1:epi_pkg::HALF_W]));
                pl_reg[i] <= epi_pkg::RL_W'(rx[i])
                           * epi_pkg::RL_W'($signed({1'b0, rl[i][epi_pkg::HALF_W-1:0]}));
            end
            l2z_reg <= in_data.l2z;
        end
    end

    // stage 4: normal lengths and residual
    always_comb begin
        r_next = (epi_pkg::R_W'(ph_reg[0]) <<< epi_pkg::HALF_W) + epi_pkg::R_W'(pl_reg[0])
               + (epi_pkg::R_W'(ph_reg[1]) <<< epi_pkg::HALF_W) + epi_pkg::R_W'(pl_reg[1])
               + (epi_pkg::R_W'(l2z_reg) <<< epi_pkg::FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_4_reg <= sq_sum(hh_reg[0], hl_reg[0], ll_reg[0])
                      + sq_sum(hh_reg[1], hl_reg[1], ll_reg[1]);
            a2_4_reg <= sq_sum(hh_reg[2], hl_reg[2], ll_reg[2])
                      + sq_sum(hh_reg[3], hl_reg[3], ll_reg[3]);
            r_reg    <= r_next;
        end
    end

    // stage 5: 16*|R| in three limbs, limb products
    always_comb begin
        rmag  = r_reg[epi_pkg::R_W-1] ? -r_reg : r_reg;
        s_val = {rmag[epi_pkg::R_W-2:0], {epi_pkg::FRAC_BITS{1'b0}}};
        s_pad = SP_W'(s_val);
        for (int i = 0; i < 3; i++) begin
            limb[i] = s_pad[i*epi_pkg::LIMB_W +: epi_pkg::LIMB_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg[0] <= epi_pkg::PP_W'(limb[0]) * epi_pkg::PP_W'(limb[0]);
            pp_reg[1] <= epi_pkg::PP_W'(limb[1]) * epi_pkg::PP_W'(limb[1]);
            pp_reg[2] <= epi_pkg::PP_W'(limb[2]) * epi_pkg::PP_W'(limb[2]);
            pp_reg[3] <= epi_pkg::PP_W'(limb[0]) * epi_pkg::PP_W'(limb[1]);
            pp_reg[4] <= epi_pkg::PP_W'(limb[0]) * epi_pkg::PP_W'(limb[2]);
            pp_reg[5] <= epi_pkg::PP_W'(limb[1]) * epi_pkg::PP_W'(limb[2]);
            a1_5_reg  <= a1_4_reg;
            a2_5_reg  <= a2_4_reg;
        end
    end

    // stage 6: assemble the square, cross terms doubled
    always_comb begin
        norm_next.a1  = a1_5_reg;
        norm_next.a2  = a2_5_reg;
        norm_next.rsq = epi_pkg::RSQ_W'(pp_reg[0])
                      + (epi_pkg::RSQ_W'(pp_reg[1]) << (2 * epi_pkg::LIMB_W))
                      + (epi_pkg::RSQ_W'(pp_reg[2]) << (4 * epi_pkg::LIMB_W))
                      + (epi_pkg::RSQ_W'(pp_reg[3]) << (epi_pkg::LIMB_W + 1))
                      + (epi_pkg::RSQ_W'(pp_reg[4]) << (2 * epi_pkg::LIMB_W + 1))
                      + (epi_pkg::RSQ_W'(pp_reg[5]) << (3 * epi_pkg::LIMB_W + 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg <= norm_next;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_v;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    assign out_v    = v6_reg;
    assign out_data = norm_reg;

endmodule

[hw/rtl/epi_lane.sv]
// One distance term: pipelined restoring divide rsq/A, then pipelined integer square root.
module epi_lane (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [epi_pkg::RSQ_W-1:0]    rsq,
    input  logic [epi_pkg::A_W-1:0]      a,
    output logic [epi_pkg::DIST_W-1:0]   term
);

    logic [epi_pkg::CMP_W-1:0]  p0;
    logic                       ovf0;

    logic [epi_pkg::A_W-1:0]    div_rem_reg [epi_pkg::Q_W+1];
    logic [epi_pkg::A_W-1:0]    div_den_reg [epi_pkg::Q_W+1];
    logic [epi_pkg::Q_W-1:0]    div_qd_reg  [epi_pkg::Q_W+1];
    logic                       div_ovf_reg [epi_pkg::Q_W+1];

    logic [epi_pkg::SQ_REM_W-1:0] sq_rem_reg  [epi_pkg::DIST_W];
    logic [epi_pkg::DIST_W-1:0]   sq_root_reg [epi_pkg::DIST_W];
    logic [epi_pkg::Q_W-1:0]      sq_rad_reg  [epi_pkg::DIST_W];
    logic                         sq_ovf_reg  [epi_pkg::DIST_W];

    // entry: a quotient of 2^Q_W or more saturates the term (covers A of zero)
    assign p0   = epi_pkg::CMP_W'(rsq[epi_pkg::RSQ_W-1:epi_pkg::Q_W]);
    assign ovf0 = p0 >= epi_pkg::CMP_W'(a);

    always_ff @(posedge aclk) begin
        if (en) begin
            div_rem_reg[0] <= epi_pkg::A_W'(p0);
            div_den_reg[0] <= a;
            div_qd_reg[0]  <= rsq[epi_pkg::Q_W-1:0];
            div_ovf_reg[0] <= ovf0;
        end
    end

    // divide: one quotient bit per stage, dividend bits shift out as quotient bits shift in
    for (genvar i = 0; i < epi_pkg::Q_W; i++) begin : g_div
        logic [epi_pkg::A_W:0]   shifted, diff;
        logic                    take;
        logic [epi_pkg::A_W-1:0] rem_next;
        logic [epi_pkg::Q_W-1:0] qd_next;

        assign shifted  = {div_rem_reg[i], div_qd_reg[i][epi_pkg::Q_W-1]};
        assign diff     = shifted - {1'b0, div_den_reg[i]};
        assign take     = shifted >= {1'b0, div_den_reg[i]};
        assign rem_next = take ? diff[epi_pkg::A_W-1:0] : shifted[epi_pkg::A_W-1:0];
        assign qd_next  = {div_qd_reg[i][epi_pkg::Q_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[i+1] <= rem_next;
                div_den_reg[i+1] <= div_den_reg[i];
                div_qd_reg[i+1]  <= qd_next;
                div_ovf_reg[i+1] <= div_ovf_reg[i];
            end
        end
    end

    // square root: one root bit per stage, two radicand bits consumed each
    for (genvar j = 0; j < epi_pkg::DIST_W; j++) begin : g_sqrt
        logic [epi_pkg::SQ_REM_W-1:0] rem_in;
        logic [epi_pkg::DIST_W-1:0]   root_in;
        logic [epi_pkg::Q_W-1:0]      rad_in;
        logic                         ovf_in;
        logic [epi_pkg::SQ_TRY_W-1:0] try_val, trial, diff;
        logic                         take;
        logic [epi_pkg::SQ_REM_W-1:0] rem_next;
        logic [epi_pkg::DIST_W-1:0]   root_next;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = div_qd_reg[epi_pkg::Q_W];
            assign ovf_in  = div_ovf_reg[epi_pkg::Q_W];
        end else begin : g_rest
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign rad_in  = sq_rad_reg[j-1];
            assign ovf_in  = sq_ovf_reg[j-1];
        end

        assign try_val   = {rem_in, rad_in[epi_pkg::Q_W-1:epi_pkg::Q_W-2]};
        assign trial     = epi_pkg::SQ_TRY_W'({root_in, 2'b01});
        assign diff      = try_val - trial;
        assign take      = try_val >= trial;
        assign rem_next  = take ? diff[epi_pkg::SQ_REM_W-1:0] : try_val[epi_pkg::SQ_REM_W-1:0];
        assign root_next = {root_in[epi_pkg::DIST_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[j]  <= rem_next;
                sq_root_reg[j] <= root_next;
                sq_rad_reg[j]  <= {rad_in[epi_pkg::Q_W-3:0], 2'b00};
                sq_ovf_reg[j]  <= ovf_in;
            end
        end
    end

    assign term = sq_ovf_reg[epi_pkg::DIST_W-1] ? epi_pkg::DIST_MAX
                                                : sq_root_reg[epi_pkg::DIST_W-1];

endmodule

[hw/rtl/epi_chk.sv]
// Port-level checker for the epipolar inlier test, bound to the top level.
module epi_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input epi_pkg::out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a saturated distance is never an inlier
    a_sat_outlier: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_inlier |-> m_data.distance != epi_pkg::DIST_MAX)
        else $error("inlier flagged at saturated distance");

    // input side only blocks behind a waiting result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without output backpressure");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind epipolar_inlier_test epi_chk u_epi_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
